/* rtl/rld_pkg.sv */
`timescale 1ns / 1ps

package rld_pkg;

   // Command byte and data byte values that together close a stream
   localparam logic [7:0] END_CODE = 8'hFF;

   // Command byte: top bit selects run, low seven bits hold count minus one
   localparam int unsigned RUN_BIT = 7;

   // Decoding stops once a command completes at or beyond this output index
   localparam logic [9:0] OUTPUT_LIMIT = 10'd864;

   typedef struct packed {
      logic [8:0] tile_value;
      logic [7:0] run_length;
      logic [9:0] start_position;
      logic       last;
   } rsp_payload_type;

endpackage

/* rtl/rld_if.sv */
`timescale 1ns / 1ps

interface rld_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       start_req;

   modport source (output valid, output data_byte, output start_req, input ready);
   modport sink (input valid, input data_byte, input start_req, output ready);
endinterface

interface rld_rsp_if;
   logic       valid;
   logic       ready;
   logic [8:0] tile_value;
   logic [7:0] run_length;
   logic [9:0] start_position;
   logic       last;

   modport source (output valid, output tile_value, output run_length,
                   output start_position, output last, input ready);
   modport sink (input valid, input tile_value, input run_length,
                 input start_position, input last, output ready);
endinterface

interface rld_csr_if;
   logic       valid;
   logic       ready;
   logic [8:0] tile_offset;

   modport source (output valid, output tile_offset, input ready);
   modport sink (input valid, input tile_offset, output ready);
endinterface

/* rtl/run_literal_rle_decoder_core.sv */
`timescale 1ns / 1ps

// Run/literal RLE decoder for background tile numbers.
// req_bus: one compressed stream byte per request; start_req = 1 restarts
//    decoding with that byte as the first command byte.
// rsp_bus: one result per run (value, length, start index) and one per
//    literal (length 1). An FF FF pair gives an end marker of length 0 with
//    last = 1; a command that completes at or past the output limit also
//    carries last = 1. After that, bytes give no result until start_req.
// csr_bus: tile_offset, added to every decoded byte; always ready. The user
//    must write it only while the decoder is idle; the block does not enforce it.
// A request passes the input register, then the result register. Throughput
//    is one request per cycle while the receiver does not stall, set by the
//    single decode step between the two registers.
// A command byte alone produces no result.
// Reset clears the decode state and tile_offset; decoding begins at once.
// A stalled receiver holds the result register; the input register then
//    holds too, and req_bus.ready drops once both are full.
module run_literal_rle_decoder_core (
   input  logic     clock,
   input  logic     reset,
   rld_req_if.sink  req_bus,
   rld_rsp_if.source rsp_bus,
   rld_csr_if.sink  csr_bus
);

   typedef enum logic [1:0] {
      PH_CMD  = 2'd0,
      PH_DATA = 2'd1,
      PH_LIT  = 2'd2
   } phase_type;

   // input register
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff, in_byte_in;
   logic       in_start_ff, in_start_in;

   // decode state
   phase_type  phase_ff, phase_in;
   logic [7:0] cmd_ff, cmd_in;
   logic [6:0] lit_ff, lit_in;
   logic [9:0] pos_ff, pos_in;
   logic       fin_ff, fin_in;
   logic [8:0] offset_ff, offset_in;

   // result register
   logic                    rsp_valid_ff, rsp_valid_in;
   rld_pkg::rsp_payload_type rsp_ff, rsp_in;

   logic advance;   // result register free to load
   logic fire;      // input register item consumed this cycle

   // working copies after an optional restart
   phase_type  ph_w;
   logic [7:0] cmd_w;
   logic [6:0] lit_w;
   logic [9:0] pos_w;
   logic       fin_w;
   logic [8:0] value;
   logic [7:0] len;
   logic [9:0] pos_next;
   logic       has_result;
   rld_pkg::rsp_payload_type result;

   assign advance       = !rsp_valid_ff || rsp_bus.ready;
   assign fire          = in_valid_ff && advance;
   assign req_bus.ready = !in_valid_ff || advance;
   assign csr_bus.ready = 1'b1;

   assign offset_in = (csr_bus.valid) ? csr_bus.tile_offset : offset_ff;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      in_start_in = in_start_ff;
      if (req_bus.ready) begin
         in_valid_in = req_bus.valid;
         in_byte_in  = req_bus.data_byte;
         in_start_in = req_bus.start_req;
      end
   end

   // single decode step
   always_comb begin
      ph_w  = in_start_ff ? PH_CMD : phase_ff;
      cmd_w = in_start_ff ? 8'd0   : cmd_ff;
      lit_w = in_start_ff ? 7'd0   : lit_ff;
      pos_w = in_start_ff ? 10'd0  : pos_ff;
      fin_w = in_start_ff ? 1'b0   : fin_ff;

      value    = 9'({1'b0, in_byte_ff} + offset_ff);
      len      = {1'b0, cmd_w[6:0]} + 8'd1;
      pos_next = pos_w;

      phase_in   = ph_w;
      cmd_in     = cmd_w;
      lit_in     = lit_w;
      fin_in     = fin_w;
      has_result = 1'b0;
      result.tile_value     = value;
      result.run_length     = 8'd1;
      result.start_position = pos_w;
      result.last           = 1'b0;

      if (!fin_w) begin
         case (ph_w)
            PH_DATA: begin
               has_result = 1'b1;
               if (cmd_w == rld_pkg::END_CODE && in_byte_ff == rld_pkg::END_CODE) begin
                  // end marker
                  fin_in            = 1'b1;
                  phase_in          = PH_CMD;
                  result.tile_value = 9'd0;
                  result.run_length = 8'd0;
                  result.last       = 1'b1;
               end else if (cmd_w[rld_pkg::RUN_BIT]) begin
                  pos_next          = pos_w + {2'b00, len};
                  phase_in          = PH_CMD;
                  result.run_length = len;
                  result.last       = (pos_next >= rld_pkg::OUTPUT_LIMIT);
                  fin_in            = result.last;
               end else begin
                  pos_next = pos_w + 10'd1;
                  lit_in   = cmd_w[6:0];
                  if (cmd_w[6:0] == 7'd0) begin
                     phase_in    = PH_CMD;
                     result.last = (pos_next >= rld_pkg::OUTPUT_LIMIT);
                     fin_in      = result.last;
                  end else begin
                     phase_in = PH_LIT;
                  end
               end
            end
            PH_LIT: begin
               has_result = 1'b1;
               pos_next   = pos_w + 10'd1;
               lit_in     = lit_w - 7'd1;
               if (lit_w == 7'd1) begin
                  phase_in    = PH_CMD;
                  result.last = (pos_next >= rld_pkg::OUTPUT_LIMIT);
                  fin_in      = result.last;
               end
            end
            default: begin
               // command byte; an unused phase code decodes as this too
               cmd_in   = in_byte_ff;
               phase_in = PH_DATA;
            end
         endcase
      end
      pos_in = pos_next;
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (advance) begin
         rsp_valid_in = fire && has_result;
         rsp_in       = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         phase_ff     <= PH_CMD;
         cmd_ff       <= 8'd0;
         lit_ff       <= 7'd0;
         pos_ff       <= 10'd0;
         fin_ff       <= 1'b0;
         offset_ff    <= 9'd0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         offset_ff    <= offset_in;
         if (fire) begin
            phase_ff <= phase_in;
            cmd_ff   <= cmd_in;
            lit_ff   <= lit_in;
            pos_ff   <= pos_in;
            fin_ff   <= fin_in;
         end
      end
      in_byte_ff  <= in_byte_in;
      in_start_ff <= in_start_in;
      rsp_ff      <= rsp_in;
   end

   assign rsp_bus.valid          = rsp_valid_ff;
   assign rsp_bus.tile_value     = rsp_ff.tile_value;
   assign rsp_bus.run_length     = rsp_ff.run_length;
   assign rsp_bus.start_position = rsp_ff.start_position;
   assign rsp_bus.last           = rsp_ff.last;

endmodule

/* rtl/rld_checker.sv */
`timescale 1ns / 1ps

module rld_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [8:0] rsp_tile_value,
   input logic [7:0] rsp_run_length,
   input logic [9:0] rsp_start_position,
   input logic       rsp_last
);

   // nothing comes out right after reset
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // a stalled response holds its contents
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_tile_value)
         && $stable(rsp_run_length) && $stable(rsp_start_position) && $stable(rsp_last))
      else $error("stalled response changed");

   // runs never exceed 128 copies
   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_run_length <= 8'd128)
      else $error("run length above 128");

   // a zero length response is the end marker
   a_end_marker: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_run_length == 8'd0 |-> rsp_last && rsp_tile_value == 9'd0)
      else $error("malformed end marker");

endmodule

bind run_literal_rle_decoder_core rld_checker u_rld_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_bus.valid),
   .rsp_ready          (rsp_bus.ready),
   .rsp_tile_value     (rsp_bus.tile_value),
   .rsp_run_length     (rsp_bus.run_length),
   .rsp_start_position (rsp_bus.start_position),
   .rsp_last           (rsp_bus.last)
);

/* test/rld_scoreboard_pkg.sv */
`timescale 1ns / 1ps

package rld_scoreboard_pkg;
   import rld_pkg::*;

   typedef enum logic [1:0] {WAIT_CMD, WAIT_DATA, WAIT_LIT} decode_phase_type;

   class tile_scoreboard_type;
      logic [8:0]       offset;
      decode_phase_type phase;
      logic [7:0]       cmd;
      logic [6:0]       lits_left;
      logic [9:0]       position;
      bit               stopped;
      rsp_payload_type  pending[$];
      int               errors;
      int               checked;
      int               markers;
      int               limit_hits;

      function new();
         offset = '0;
         clear_stream();
      endfunction

      function void clear_stream();
         phase     = WAIT_CMD;
         cmd       = '0;
         lits_left = '0;
         position  = '0;
         stopped   = 1'b0;
      endfunction

      function void queue_tile(logic [8:0] val, logic [7:0] len, logic [9:0] at, logic fin);
         rsp_payload_type t;
         t.tile_value     = val;
         t.run_length     = len;
         t.start_position = at;
         t.last           = fin;
         pending.push_back(t);
      endfunction

      // command finished: back to command phase, stop once at or past the limit
      function logic close_command();
         phase = WAIT_CMD;
         if (position >= OUTPUT_LIMIT) begin
            stopped = 1'b1;
            limit_hits++;
            return 1'b1;
         end
         return 1'b0;
      endfunction

      // one accepted request; queues the result it causes, if any
      function void note_request(logic [7:0] b, logic st);
         logic [8:0] val;
         logic [7:0] len;
         logic [9:0] at;
         val = {1'b0, b} + offset;
         if (st)
            clear_stream();
         if (stopped)
            return;
         case (phase)
            WAIT_DATA: begin
               at = position;
               if (cmd == END_CODE && b == END_CODE) begin
                  stopped = 1'b1;
                  phase   = WAIT_CMD;
                  markers++;
                  queue_tile('0, '0, at, 1'b1);
               end else if (cmd[RUN_BIT]) begin
                  len      = {1'b0, cmd[6:0]} + 8'd1;
                  position = position + 10'(len);
                  queue_tile(val, len, at, close_command());
               end else begin
                  position  = position + 10'd1;
                  lits_left = cmd[6:0];
                  if (lits_left == 0) begin
                     queue_tile(val, 8'd1, at, close_command());
                  end else begin
                     phase = WAIT_LIT;
                     queue_tile(val, 8'd1, at, 1'b0);
                  end
               end
            end
            WAIT_LIT: begin
               at        = position;
               position  = position + 10'd1;
               lits_left = lits_left - 7'd1;
               if (lits_left == 0)
                  queue_tile(val, 8'd1, at, close_command());
               else
                  queue_tile(val, 8'd1, at, 1'b0);
            end
            default: begin
               cmd   = b;
               phase = WAIT_DATA;
            end
         endcase
      endfunction

      task report(string what, logic [31:0] got, logic [31:0] want);
         errors++;
         $display("mismatch %0d at result %0d: %s got %0d want %0d",
                  errors, checked, what, got, want);
      endtask

      task check_result(rsp_payload_type got);
         rsp_payload_type want;
         checked++;
         if (pending.size() == 0) begin
            report("result with nothing pending, tile", got.tile_value, 0);
            return;
         end
         want = pending.pop_front();
         if (got.tile_value !== want.tile_value)
            report("tile_value", got.tile_value, want.tile_value);
         if (got.run_length !== want.run_length)
            report("run_length", got.run_length, want.run_length);
         if (got.start_position !== want.start_position)
            report("start_position", got.start_position, want.start_position);
         if (got.last !== want.last)
            report("last", got.last, want.last);
      endtask

      task flag_leftovers();
         if (pending.size() != 0)
            report("results never delivered, count", pending.size(), 0);
      endtask
   endclass

endpackage

/* test/tb.sv */
`timescale 1ns / 1ps

module tb;
   import rld_pkg::*;
   import rld_scoreboard_pkg::*;

   localparam int CLOCK_PERIOD   = 8;
   localparam int REQUEST_TARGET = 1450;
   localparam int PHASE_COUNT    = 6;
   // spare edges after the last pending result, for trailing bytes
   localparam int SETTLE_CYCLES  = 4;
   localparam int LONG_HOLD      = 300;

   logic clock;
   logic reset;

   rld_req_if req_bus();
   rld_rsp_if rsp_bus();
   rld_csr_if csr_bus();

   run_literal_rle_decoder_core DUT (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   tile_scoreboard_type board;
   rsp_payload_type     seen;
   int                  requests_sent;
   int                  phase_end;         // request count that closes the phase
   int                  streams_played;
   int                  noise_bursts;
   int                  rsp_hold_cycles;   // set by main, consumed by the receiver
   bit                  sender_calm;       // sender offers back to back

   initial begin
      clock = 1'b0;
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   // Idle gaps: every third stretch of 40 items runs without any gaps.
   function automatic int draw_gap(int count);
      if ((count / 40) % 3 == 1)
         return 0;
      return $urandom_range(0, 15);
   endfunction

   // Offer one request; valid stays up between back-to-back requests.
   task automatic send_request(logic [7:0] b, logic st);
      int gap;
      gap = sender_calm ? 0 : draw_gap(requests_sent);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.data_byte <= b;
      req_bus.start_req <= st;
      do @(posedge clock); while (!req_bus.ready);
      board.note_request(b, st);
      requests_sent++;
   endtask

   task automatic write_offset(logic [8:0] v);
      csr_bus.valid       <= 1'b1;
      csr_bus.tile_offset <= v;
      do @(posedge clock); while (!csr_bus.ready);
      csr_bus.valid <= 1'b0;
      board.offset = v;
   endtask

   // Stop offering and let every pending result come out. A trailing command
   // byte causes no result, so a few extra edges cover the pipeline.
   task automatic drain();
      req_bus.valid <= 1'b0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Well-formed stream: start flag on the first command, then runs and
   // literal groups until the output limit. Now and then it closes early
   // with the end marker or is simply abandoned; the phase budget also
   // cuts it short.
   task automatic play_stream();
      int         pos;
      int         n;
      logic       first;
      logic [7:0] cmd;
      logic [7:0] b;
      pos   = 0;
      first = 1'b1;
      streams_played++;
      while (pos < OUTPUT_LIMIT) begin
         if (requests_sent >= phase_end)
            break;
         if ($urandom_range(0, 39) == 0)
            break;
         if ($urandom_range(0, 24) == 0) begin
            send_request(END_CODE, first);
            send_request(END_CODE, 1'b0);
            break;
         end
         if ($urandom_range(0, 1) == 1) begin
            cmd = {1'b1, 7'($urandom_range(0, 127))};
            b   = 8'($urandom_range(0, 255));
            send_request(cmd, first);
            first = 1'b0;
            send_request(b, 1'b0);
            if (cmd == END_CODE && b == END_CODE)
               break;
            pos += cmd[6:0] + 1;
         end else begin
            // mostly short literal groups, some long ones
            n = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 127) : $urandom_range(0, 7);
            send_request({1'b0, 7'(n)}, first);
            first = 1'b0;
            repeat (n + 1) send_request(8'($urandom_range(0, 255)), 1'b0);
            pos += n + 1;
         end
      end
      // trailing bytes; the decoder drops them only once the stream has stopped
      repeat ($urandom_range(0, 3)) send_request(8'($urandom_range(0, 255)), 1'b0);
   endtask

   // Unstructured bytes with sporadic restarts.
   task automatic play_noise();
      noise_bursts++;
      repeat ($urandom_range(8, 30))
         send_request(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
   endtask

   // Receiver: random stalls per result, plus one long hold when asked.
   initial begin : receiver
      int gap;
      int taken;
      taken = 0;
      rsp_bus.ready <= 1'b0;
      @(posedge clock);
      forever begin
         if (rsp_hold_cycles > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (rsp_hold_cycles) @(posedge clock);
            rsp_hold_cycles = 0;
         end
         gap = draw_gap(taken + 20);
         if (gap > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!rsp_bus.valid);
         taken++;
      end
   end

   // Result monitor: every handshake is checked against the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         seen.tile_value     = rsp_bus.tile_value;
         seen.run_length     = rsp_bus.run_length;
         seen.start_position = rsp_bus.start_position;
         seen.last           = rsp_bus.last;
         board.check_result(seen);
      end
   end

   initial begin : main
      logic [8:0] offsets [PHASE_COUNT];
      int         phase_start;
      bit         paused;
      board           = new();
      requests_sent   = 0;
      phase_end       = 0;
      streams_played  = 0;
      noise_bursts    = 0;
      rsp_hold_cycles = 0;
      sender_calm     = 1'b0;
      paused          = 1'b0;
      reset               <= 1'b1;
      req_bus.valid       <= 1'b0;
      req_bus.data_byte   <= '0;
      req_bus.start_req   <= 1'b0;
      csr_bus.valid       <= 1'b0;
      csr_bus.tile_offset <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed, offset 0 from reset; decoding runs without a start flag.
      send_request(8'h80, 1'b0);       // run of one, lowest value
      send_request(8'h00, 1'b0);
      send_request(8'hFF, 1'b0);       // all-ones command, plain run of 128
      send_request(8'h12, 1'b0);
      send_request(8'h02, 1'b0);       // three literals
      send_request(8'hFF, 1'b0);
      send_request(8'h7F, 1'b0);
      send_request(8'h01, 1'b0);
      send_request(8'h00, 1'b0);       // single literal
      send_request(8'hAA, 1'b0);
      send_request(END_CODE, 1'b0);    // end marker mid-output
      send_request(END_CODE, 1'b0);
      send_request(8'h55, 1'b0);       // dropped, decoder has stopped
      send_request(8'h7F, 1'b1);       // restart into a long literal group
      send_request(8'h01, 1'b0);
      send_request(END_CODE, 1'b1);    // restart mid-group, marker at index 0
      send_request(END_CODE, 1'b0);
      drain();

      write_offset(9'd256);
      send_request(8'h80, 1'b1);       // top byte with high offset
      send_request(8'hFF, 1'b0);
      drain();

      // Full offset wraps the tile number; seven long runs cross the limit.
      write_offset(9'h1FF);
      send_request(8'hFE, 1'b1);
      send_request(8'hFF, 1'b0);
      repeat (6) begin
         send_request(8'hFF, 1'b0);
         send_request(8'h00, 1'b0);
      end
      send_request(8'h33, 1'b0);       // dropped after the limit
      drain();

      // Random phases, each starting with an offset write; some offsets repeat.
      offsets[0] = 9'd0;
      offsets[1] = 9'd256;
      offsets[2] = 9'h1FF;
      offsets[3] = 9'($urandom_range(0, 511));
      offsets[4] = 9'd256;
      offsets[5] = 9'd0;
      for (int ph = 0; ph < PHASE_COUNT; ph++) begin
         drain();
         write_offset(offsets[ph]);
         phase_start = requests_sent;
         phase_end   = phase_start + REQUEST_TARGET / PHASE_COUNT;
         if (ph == 2) begin
            // receiver holds off while the sender keeps offering
            rsp_hold_cycles = LONG_HOLD;
            sender_calm     = 1'b1;
         end
         while (requests_sent < phase_end) begin
            if ($urandom_range(0, 6) == 0)
               play_noise();
            else
               play_stream();
            if (sender_calm && requests_sent - phase_start >= 80)
               sender_calm = 1'b0;
            if (ph == 4 && !paused && requests_sent - phase_start >= 100) begin
               drain();   // sender waits for every result before going on
               paused = 1'b1;
            end
         end
      end

      // Wind down: bounded wait for the tail, then a few spare edges.
      req_bus.valid <= 1'b0;
      for (int w = 0; w < 4000 && board.pending.size() != 0; w++) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      board.flag_leftovers();

      $display("run covered %0d requests in %0d streams and %0d noise bursts, %0d results checked",
               requests_sent, streams_played, noise_bursts, board.checked);
      $display("%0d streams stopped at the output limit, %0d end markers, offsets 0, 256, 511",
               board.limit_hits, board.markers);
      if (board.errors == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

   // Watchdog, several times the slowest legal run.
   initial begin : watchdog
      #3_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule

/* sim.f */
rtl/rld_pkg.sv
rtl/rld_if.sv
rtl/run_literal_rle_decoder_core.sv
rtl/rld_checker.sv
test/rld_scoreboard_pkg.sv
test/tb.sv
